// ----- sv/sfs_pkg.sv -----
`default_nettype none
package sfs_pkg;

	localparam int MAX_FRAMES = 16;
	localparam int IDX_W      = $clog2(MAX_FRAMES);
	localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
	localparam int DUR_W      = 16;
	localparam int TOTAL_W    = DUR_W + IDX_W;
	localparam int PROG_W     = 32;
	localparam int DIV_CNT_W  = $clog2(PROG_W + 1);
	localparam int OP_W       = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	typedef enum logic [OP_W-1:0] {
		OP_TICK    = 2'd0,
		OP_WRITE   = 2'd1,
		OP_RESTART = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LOOP_MODE = 2'd0,
		CFG_FRAMES    = 2'd1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_DIV,
		ST_WALK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic accept;
		logic rd_en;
		logic sum_end;
	} cmd_t;

	typedef struct packed {
		logic n_zero;
		logic loop_mode;
		logic sum_done;
		logic total_zero;
		logic q_gt_total;
		logic div_done;
		logic walk_done;
	} status_t;

endpackage
`default_nettype wire

// ----- sv/sfs_ctrl.sv -----
`default_nettype none
module sfs_ctrl
	import sfs_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic [OP_W-1:0] opcode,
	input  wire status_t         status,
	output cmd_t                 cmd,
	output logic                 busy,
	output logic                 done
);

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign accept = start && (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (opcode != OP_TICK || status.n_zero) begin
						state_d = ST_DONE;
					end else if (status.loop_mode) begin
						state_d = ST_SUM;
					end else begin
						state_d = ST_WALK;
					end
				end
			end
			ST_SUM: begin
				if (status.sum_done) begin
					if (status.total_zero) begin
						state_d = ST_DONE;
					end else if (status.q_gt_total) begin
						state_d = ST_DIV;
					end else begin
						state_d = ST_WALK;
					end
				end
			end
			ST_DIV: begin
				if (status.div_done) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (status.walk_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd.accept  = accept;
		cmd.rd_en   = (state_q == ST_SUM) || (state_q == ST_WALK);
		cmd.sum_end = (state_q == ST_SUM) && status.sum_done;
		busy        = (state_q != ST_IDLE);
		done        = (state_q == ST_DONE);
	end

endmodule
`default_nettype wire

// ----- sv/sfs_moddiv.sv -----
`default_nettype none
// Restoring remainder unit, one dividend bit per cycle.
module sfs_moddiv
	import sfs_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [PROG_W-1:0]  dividend,
	input  wire logic [TOTAL_W-1:0] divisor,
	output logic                    done,
	output logic [TOTAL_W-1:0]      remainder
);

	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 done_q;
	logic [PROG_W-1:0]    dvd_q;
	logic [TOTAL_W-1:0]   dsr_q;
	logic [TOTAL_W-1:0]   rem_q;
	logic [TOTAL_W:0]     trial;
	logic [TOTAL_W:0]     diff;

	assign trial = {rem_q, dvd_q[PROG_W-1]};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == DIV_CNT_W'(1));
			if (start) begin
				cnt_q <= DIV_CNT_W'(PROG_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[PROG_W-2:0], 1'b0};
			if (trial >= {1'b0, dsr_q}) begin
				rem_q <= diff[TOTAL_W-1:0];
			end else begin
				rem_q <= trial[TOTAL_W-1:0];
			end
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule
`default_nettype wire

// ----- sv/sfs_datapath.sv -----
`default_nettype none
module sfs_datapath
	import sfs_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cmd_t                  cmd,
	output status_t                    status,
	input  wire logic [OP_W-1:0]       opcode,
	input  wire logic [DUR_W-1:0]      elapsed_time,
	input  wire logic [IDX_W-1:0]      frame_select,
	input  wire logic [DUR_W-1:0]      duration_value,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output logic [IDX_W-1:0]           current_frame
);

	logic [DUR_W-1:0]   mem [MAX_FRAMES];

	logic               loop_q;
	logic [CNT_W-1:0]   frames_q;
	logic [PROG_W-1:0]  progress_q;
	logic [PROG_W-1:0]  q_q;
	logic [IDX_W-1:0]   frame_q;
	logic [CNT_W-1:0]   idx_q;
	logic [TOTAL_W-1:0] acc_q;
	logic [DUR_W-1:0]   rd_s1;
	logic [CNT_W-1:0]   rd_idx_s1;
	logic               rdv_s1;

	logic [CNT_W-1:0]   n_act;
	logic [PROG_W:0]    prog_sum;
	logic [PROG_W-1:0]  prog_next;
	logic [TOTAL_W-1:0] cum;
	logic               is_last;
	logic               hit;
	logic               div_start;
	logic               div_done;
	logic [TOTAL_W-1:0] div_rem;

	assign n_act = (frames_q > CNT_W'(MAX_FRAMES)) ? CNT_W'(MAX_FRAMES) : frames_q;

	// saturating progress add
	assign prog_sum  = {1'b0, progress_q} + {{(PROG_W+1-DUR_W){1'b0}}, elapsed_time};
	assign prog_next = prog_sum[PROG_W] ? '1 : prog_sum[PROG_W-1:0];

	// running sum including the beat now on the read port
	assign cum     = acc_q + {{(TOTAL_W-DUR_W){1'b0}}, rd_s1};
	assign is_last = (rd_idx_s1 == n_act - 1'b1);
	assign hit     = rdv_s1 && ((q_q <= PROG_W'(cum)) || is_last);

	assign div_start = cmd.sum_end && (cum != '0) && (q_q > PROG_W'(cum));

	sfs_moddiv u_moddiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (q_q - 1'b1),
		.divisor   (cum),
		.done      (div_done),
		.remainder (div_rem)
	);

	always_ff @(posedge clk) begin
		if (cmd.accept && opcode == OP_WRITE) begin
			mem[frame_select] <= duration_value;
		end
		rd_s1 <= mem[idx_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_q     <= 1'b0;
			frames_q   <= CNT_W'(1);
			progress_q <= '0;
			q_q        <= '0;
			frame_q    <= '0;
			idx_q      <= '0;
			acc_q      <= '0;
			rd_idx_s1  <= '0;
			rdv_s1     <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_LOOP_MODE: loop_q   <= cfg_data[0];
					CFG_FRAMES:    frames_q <= cfg_data[CNT_W-1:0];
					default: ;
				endcase
			end

			if (div_done) begin
				q_q <= PROG_W'(div_rem) + 1'b1;
			end

			if (cmd.accept) begin
				idx_q  <= '0;
				acc_q  <= '0;
				rdv_s1 <= 1'b0;
				case (opcode)
					OP_TICK: begin
						progress_q <= prog_next;
						q_q        <= prog_next;
					end
					OP_RESTART: begin
						progress_q <= '0;
						frame_q    <= '0;
					end
					default: ;
				endcase
			end else if (cmd.sum_end) begin
				idx_q  <= '0;
				acc_q  <= '0;
				rdv_s1 <= 1'b0;
				if (cum == '0) begin
					frame_q <= '0;
				end
			end else begin
				if (cmd.rd_en) begin
					idx_q     <= idx_q + 1'b1;
					rd_idx_s1 <= idx_q;
					rdv_s1    <= (idx_q < n_act);
				end
				if (rdv_s1) begin
					acc_q <= cum;
				end
				// frame only moves here while the sum or walk pass is reading
				if (hit && cmd.rd_en) begin
					frame_q <= rd_idx_s1[IDX_W-1:0];
				end
			end
		end
	end

	always_comb begin
		status.n_zero     = (n_act == '0);
		status.loop_mode  = loop_q;
		status.sum_done   = rdv_s1 && is_last;
		status.total_zero = (cum == '0);
		status.q_gt_total = (q_q > PROG_W'(cum));
		status.div_done   = div_done;
		status.walk_done  = hit;
	end

	assign current_frame = frame_q;

endmodule
`default_nettype wire

// ----- sv/sprite_frame_sequencer_core.sv -----
`default_nettype none
// Sprite animation frame sequencer.
// Command channel: an item is taken on a clock edge with start high and busy low.
// opcode tick adds elapsed_time to the progress counter (saturating) and picks
// the frame; write stores duration_value for frame_select; restart clears
// progress and the shown frame. Each item yields one result: done pulses high
// for one cycle with current_frame valid. The receiver cannot stall; done is
// a pure strobe and the next item may start on the cycle after it.
// Write, restart and unused opcodes finish in the cycle after accept.
// A tick in once mode walks the duration memory, one entry per cycle, to
// pick the frame. In loop mode a totals pass over the memory comes first,
// and a wrap then runs the bit-serial remainder unit; the tick's length is
// set by the single memory read port and the one-bit-per-cycle remainder
// step.
// Config channel (cfg_valid/cfg_ready, always ready) writes loop_mode at
// index 0 and frames_in_use at index 1; write only while busy is low.
// Reset: progress and shown frame clear, loop_mode 0, frames_in_use 1;
// duration memory is unset until written.
module sprite_frame_sequencer_core
	import sfs_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [OP_W-1:0]       opcode,
	input  wire logic [DUR_W-1:0]      elapsed_time,
	input  wire logic [IDX_W-1:0]      frame_select,
	input  wire logic [DUR_W-1:0]      duration_value,
	output logic                       done,
	output logic [IDX_W-1:0]           current_frame,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t    cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	sfs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	sfs_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.opcode         (opcode),
		.elapsed_time   (elapsed_time),
		.frame_select   (frame_select),
		.duration_value (duration_value),
		.cfg_we         (cfg_valid & cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.current_frame  (current_frame)
	);

endmodule
`default_nettype wire

// ----- bench/sfs_checker.sv -----
`default_nettype none
module sfs_checker
	import sfs_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic                  busy,
	input  wire logic [OP_W-1:0]       opcode,
	input  wire logic [DUR_W-1:0]      elapsed_time,
	input  wire logic [IDX_W-1:0]      frame_select,
	input  wire logic [DUR_W-1:0]      duration_value,
	input  wire logic                  done,
	input  wire logic [IDX_W-1:0]      current_frame,
	input  wire logic                  cfg_valid,
	input  wire logic                  cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output int                         errors,
	output int                         pending
);

	logic                  loop_on     = 1'b0;
	logic [CFG_DATA_W-1:0] frame_count = CFG_DATA_W'(1);
	logic [DUR_W-1:0]      dur_tbl [MAX_FRAMES] = '{default: '0};
	logic [PROG_W-1:0]     progress    = '0;
	logic [IDX_W-1:0]      shown       = '0;
	logic [IDX_W-1:0]      expected_frames [$];
	logic [IDX_W-1:0]      want_frame;
	int                    mismatches  = 0;

	// first frame whose running duration sum reaches progress, else the last
	function automatic void select_frame();
		int unsigned       n;
		int unsigned       total;
		int unsigned       cum;
		logic [PROG_W-1:0] q;
		n = (frame_count > MAX_FRAMES) ? MAX_FRAMES : frame_count;
		q = progress;
		total = 0;
		cum = 0;
		if (n == 0)
			return;
		if (loop_on) begin
			for (int i = 0; i < n; i++)
				total += dur_tbl[i];
			if (total == 0) begin
				shown = '0;
				return;
			end
			// exact multiple of the total lands on the last frame
			if (q > total)
				q = ((q - 1) % total) + 1;
		end
		for (int i = 0; i < n; i++) begin
			cum += dur_tbl[i];
			if (q <= cum || i == n - 1) begin
				shown = IDX_W'(i);
				return;
			end
		end
	endfunction

	function automatic logic [IDX_W-1:0] advance_sequence(
		input logic [OP_W-1:0]  op,
		input logic [DUR_W-1:0] el,
		input logic [IDX_W-1:0] sel,
		input logic [DUR_W-1:0] dur
	);
		case (op)
			OP_TICK: begin
				if (progress > {PROG_W{1'b1}} - PROG_W'(el))
					progress = {PROG_W{1'b1}};
				else
					progress = progress + PROG_W'(el);
				select_frame();
			end
			OP_WRITE: dur_tbl[sel] = dur;
			OP_RESTART: begin
				progress = '0;
				shown = '0;
			end
			default: ;
		endcase
		return shown;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_on = 1'b0;
			frame_count = CFG_DATA_W'(1);
			progress = '0;
			shown = '0;
			expected_frames.delete();
			errors <= mismatches;
			pending <= 0;
		end else begin
			if (done) begin
				if (expected_frames.size() == 0) begin
					mismatches++;
					$error("current_frame: expected no result, actual %0d", current_frame);
				end else begin
					want_frame = expected_frames.pop_front();
					if (current_frame !== want_frame) begin
						mismatches++;
						$error("current_frame: expected %0d, actual %0d",
							want_frame, current_frame);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_LOOP_MODE: loop_on = cfg_data[0];
					CFG_FRAMES:    frame_count = cfg_data;
					default: ;
				endcase
			end
			if (start && !busy)
				expected_frames = {expected_frames, advance_sequence(opcode,
					elapsed_time, frame_select, duration_value)};
			errors <= mismatches;
			pending <= expected_frames.size();
		end
	end

endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
`default_nettype none
module testbench;
	import sfs_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int IDLE_LIMIT  = 2000;
	localparam int BURST_TICKS = 40;
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 64;
	localparam logic [7:0] LOOP_SEQ = 8'b01011010;
	localparam int FRAMES_SEQ [8] = '{1, 16, 16, 1, 0, 31, 2, 17};

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [OP_W-1:0]       opcode;
	logic [DUR_W-1:0]      elapsed_time;
	logic [IDX_W-1:0]      frame_select;
	logic [DUR_W-1:0]      duration_value;
	logic                  done;
	logic [IDX_W-1:0]      current_frame;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    errors;
	int                    pending;
	int                    idle_cycles = 0;
	bit                    no_idle;

	sprite_frame_sequencer_core u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.opcode         (opcode),
		.elapsed_time   (elapsed_time),
		.frame_select   (frame_select),
		.duration_value (duration_value),
		.done           (done),
		.current_frame  (current_frame),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	sfs_checker u_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.opcode         (opcode),
		.elapsed_time   (elapsed_time),
		.frame_select   (frame_select),
		.duration_value (duration_value),
		.done           (done),
		.current_frame  (current_frame),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.errors         (errors),
		.pending        (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// stall watchdog: cycles with no beat on any channel
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL sprite_frame_sequencer_core");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// mix of extremes and narrow ranges so small durations and ticks interact
	function automatic logic [DUR_W-1:0] pick16();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			2, 3:    return DUR_W'($urandom_range(0, 15));
			4:       return DUR_W'($urandom_range(0, 255));
			5:       return DUR_W'($urandom_range(0, 4095));
			default: return DUR_W'($urandom);
		endcase
	endfunction

	task automatic send_item(
		input logic [OP_W-1:0]  op,
		input logic [DUR_W-1:0] el,
		input logic [IDX_W-1:0] sel,
		input logic [DUR_W-1:0] dur
	);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		opcode <= op;
		elapsed_time <= el;
		frame_select <= sel;
		duration_value <= dur;
		@(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
	endtask

	task automatic send_random();
		int r;
		logic [OP_W-1:0] op;
		r = $urandom_range(0, 99);
		if (r < 55)
			op = OP_TICK;
		else if (r < 80)
			op = OP_WRITE;
		else if (r < 93)
			op = OP_RESTART;
		else
			op = OP_UNUSED;
		send_item(op, pick16(), IDX_W'($urandom_range(0, MAX_FRAMES - 1)), pick16());
	endtask

	// hold off new commands until every outstanding result is back
	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic set_config(input logic lp, input logic [CFG_DATA_W-1:0] nf);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_index <= CFG_LOOP_MODE;
		cfg_data <= CFG_DATA_W'(lp);
		@(posedge clk);
		while (cfg_ready !== 1'b1) @(posedge clk);
		cfg_index <= CFG_FRAMES;
		cfg_data <= nf;
		@(posedge clk);
		while (cfg_ready !== 1'b1) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic                  lp;
		logic [CFG_DATA_W-1:0] nf;
		arst_n = 1'b0;
		start = 1'b0;
		opcode = OP_TICK;
		elapsed_time = '0;
		frame_select = '0;
		duration_value = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_LOOP_MODE;
		cfg_data = '0;
		no_idle = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// fill the whole table first so no tick ever reads an unset entry
		for (int i = 0; i < MAX_FRAMES; i++)
			send_item(OP_WRITE, pick16(), IDX_W'(i),
				(i == 0) ? DUR_W'(0) : (i == 1) ? '1 : DUR_W'(i * 7 + 3));

		// single frame, once mode
		send_item(OP_TICK, '0, '0, '0);
		send_item(OP_TICK, '1, '1, '1);
		send_item(OP_UNUSED, '1, '1, '1);
		send_item(OP_RESTART, '1, '1, '1);

		// loop over {0, 65535}: exact multiple stays on the last frame
		set_config(1'b1, CFG_DATA_W'(2));
		send_item(OP_TICK, '1, '0, '0);
		send_item(OP_TICK, '1, '0, '0);
		send_item(OP_TICK, DUR_W'(1), '0, '0);

		// zero total in loop mode shows frame 0
		set_config(1'b1, CFG_DATA_W'(1));
		send_item(OP_TICK, DUR_W'(7), '0, '0);

		// no frames: frame held, progress still counts
		set_config(1'b0, CFG_DATA_W'(0));
		send_item(OP_TICK, DUR_W'(5), '0, '0);

		// count above the table size clamps; a write alone keeps the frame
		set_config(1'b1, '1);
		send_item(OP_RESTART, '0, '0, '0);
		send_item(OP_TICK, '1, '0, '0);
		send_item(OP_WRITE, '0, IDX_W'(1), DUR_W'(3));
		send_item(OP_TICK, '0, '0, '0);

		// back-to-back full-size ticks
		set_config(1'b0, CFG_DATA_W'(0));
		send_item(OP_RESTART, '0, '0, '0);
		no_idle = 1'b1;
		for (int i = 0; i < BURST_TICKS; i++)
			send_item(OP_TICK, '1, '0, '0);
		no_idle = 1'b0;
		set_config(1'b1, CFG_DATA_W'(MAX_FRAMES));
		send_item(OP_TICK, '0, '0, '0);
		send_item(OP_TICK, pick16(), '0, '0);
		set_config(1'b0, CFG_DATA_W'(MAX_FRAMES));
		send_item(OP_TICK, '1, '0, '0);
		send_item(OP_RESTART, '0, '0, '0);

		for (int p = 0; p < PHASES; p++) begin
			lp = (p < 8) ? LOOP_SEQ[p] : 1'($urandom_range(0, 1));
			nf = (p < 8) ? CFG_DATA_W'(FRAMES_SEQ[p]) : CFG_DATA_W'($urandom_range(0, 31));
			set_config(lp, nf);
			send_item(OP_RESTART, pick16(), '0, pick16());
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (k % 20 == 0)
					no_idle = ($urandom_range(0, 3) == 0);
				send_random();
			end
		end

		wait_drained();
		repeat (80) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("PASS sprite_frame_sequencer_core");
		else
			$display("FAIL sprite_frame_sequencer_core");
		$finish;
	end

endmodule
`default_nettype wire

// ----- filelist.f -----
sv/sfs_pkg.sv
sv/sfs_ctrl.sv
sv/sfs_moddiv.sv
sv/sfs_datapath.sv
sv/sprite_frame_sequencer_core.sv
bench/sfs_checker.sv
bench/testbench.sv
